// File: sv/bsc_pkg.sv
// Shared constants and types for the barometric sensor compensation block.
package bsc_pkg;

    // Calibration register indexes
    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4
    } t_reg_idx;

    localparam int NUM_REGS = 5;
    localparam int IDX_W    = 3;

    // Sideband width carried through each divider pipeline
    localparam int SIDE_W = 50;
    localparam int DIV_W  = 32;

    // Compensation constants
    localparam logic [31:0] C_4000   = 32'd4000;
    localparam logic [31:0] C_32768  = 32'd32768;
    localparam logic [31:0] C_50000  = 32'd50000;
    localparam logic [31:0] C_3038   = 32'd3038;
    localparam logic [31:0] C_M7357  = -32'sd7357;
    localparam logic [31:0] C_3791   = 32'd3791;
    localparam logic [31:0] C_40     = 32'd40;

endpackage

// File: sv/bsc_div.sv
// Fully pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module bsc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [bsc_pkg::DIV_W-1:0]  i_dvd,
    input  logic [bsc_pkg::DIV_W-1:0]  i_dvs,
    input  logic [bsc_pkg::SIDE_W-1:0] i_side,
    output logic                       o_vld,
    output logic [bsc_pkg::DIV_W-1:0]  o_quo,
    output logic [bsc_pkg::SIDE_W-1:0] o_side
);
    localparam int N = bsc_pkg::DIV_W;

    logic                       r_vld  [0:N];
    logic [N-1:0]               r_rem  [0:N];
    logic [N-1:0]               r_quo  [0:N];
    logic [N-1:0]               r_dvs  [0:N];
    logic [bsc_pkg::SIDE_W-1:0] r_side [0:N];

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rem[0]  <= '0;
        r_quo[0]  <= i_dvd;
        r_dvs[0]  <= i_dvs;
        r_side[0] <= i_side;
    end

    // One shift-compare-subtract per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N:0] w_trial;
        logic       w_ge;
        assign w_trial = {r_rem[k], r_quo[k][N-1]};
        assign w_ge    = (w_trial >= {1'b0, r_dvs[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= w_ge ? N'(w_trial - {1'b0, r_dvs[k]}) : w_trial[N-1:0];
            r_quo[k+1]  <= {r_quo[k][N-2:0], w_ge};
            r_dvs[k+1]  <= r_dvs[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[N];
    assign o_quo  = r_quo[N];
    assign o_side = r_side[N];

endmodule

// File: sv/barometric_sensor_compensation.sv
// Top level: pipelined barometric temperature and pressure compensation.
//
// One raw temperature/pressure pair is taken on every cycle that start is high
// (busy is always low). The matching result appears on o_valid for one cycle
// and cannot be held off. Most of the pipeline depth comes from the two divider
// pipelines, one for the temperature term and one for the pressure quotient.
// The other stages are the multiply stages and the reciprocal scaling by 40.
// Calibration words are to be written through the cfg channel while no item is
// in flight; the block itself does not enforce this. That channel is always
// ready.
module barometric_sensor_compensation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 i_raw_temp,
    input  logic [15:0]                 i_raw_press,
    output logic                        o_valid,
    output logic signed [15:0]          o_temp_tenths_c,
    output logic signed [15:0]          o_press_tenths_mmhg,
    output logic                        o_div_error,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bsc_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                 i_cfg_data
);
    localparam int SW = bsc_pkg::SIDE_W;

    // Calibration registers
    logic [31:0] r_cal [0:bsc_pkg::NUM_REGS-1];

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bsc_pkg::NUM_REGS; i++) r_cal[i] <= '0;
        end else if (i_cfg_valid && o_cfg_ready &&
                     (i_cfg_index < bsc_pkg::IDX_W'(bsc_pkg::NUM_REGS))) begin
            r_cal[i_cfg_index] <= i_cfg_data;
        end
    end

    // Decoded calibration words, extended to 32 bits
    logic [31:0] w_ac1, w_ac2, w_ac3, w_ac4, w_ac5, w_ac6, w_b1, w_b2, w_mc, w_md;
    assign w_ac1 = {{16{r_cal[bsc_pkg::REG_AC1_AC2][31]}}, r_cal[bsc_pkg::REG_AC1_AC2][31:16]};
    assign w_ac2 = {{16{r_cal[bsc_pkg::REG_AC1_AC2][15]}}, r_cal[bsc_pkg::REG_AC1_AC2][15:0]};
    assign w_ac3 = {{16{r_cal[bsc_pkg::REG_AC3_AC4][31]}}, r_cal[bsc_pkg::REG_AC3_AC4][31:16]};
    assign w_ac4 = {16'd0, r_cal[bsc_pkg::REG_AC3_AC4][15:0]};
    assign w_ac5 = {16'd0, r_cal[bsc_pkg::REG_AC5_AC6][31:16]};
    assign w_ac6 = {16'd0, r_cal[bsc_pkg::REG_AC5_AC6][15:0]};
    assign w_b1  = {{16{r_cal[bsc_pkg::REG_B1_B2][31]}}, r_cal[bsc_pkg::REG_B1_B2][31:16]};
    assign w_b2  = {{16{r_cal[bsc_pkg::REG_B1_B2][15]}}, r_cal[bsc_pkg::REG_B1_B2][15:0]};
    assign w_mc  = {{16{r_cal[bsc_pkg::REG_MC_MD][31]}}, r_cal[bsc_pkg::REG_MC_MD][31:16]};
    assign w_md  = {{16{r_cal[bsc_pkg::REG_MC_MD][15]}}, r_cal[bsc_pkg::REG_MC_MD][15:0]};

    // Stage A: input capture
    logic        r_a_v;
    logic [15:0] r_a_ut, r_a_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else          r_a_v <= start && !busy;
        r_a_ut <= i_raw_temp;
        r_a_up <= i_raw_press;
    end

    // Stage B: x1 = (ut - ac6) * ac5 >> 15
    logic [31:0] w_prod1;
    logic        r_b_v;
    logic [31:0] r_b_x1;
    logic [15:0] r_b_up;
    assign w_prod1 = ({16'd0, r_a_ut} - w_ac6) * w_ac5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else          r_b_v <= r_a_v;
        r_b_x1 <= $unsigned($signed(w_prod1) >>> 15);
        r_b_up <= r_a_up;
    end

    // Stage C: signed magnitudes for mc << 11 / (x1 + md)
    logic [31:0] w_den, w_num;
    logic        r_c_v, r_c_neg, r_c_zero;
    logic [31:0] r_c_ma, r_c_mb, r_c_x1;
    logic [15:0] r_c_up;
    assign w_den = r_b_x1 + w_md;
    assign w_num = w_mc << 11;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else          r_c_v <= r_b_v;
        r_c_ma   <= w_num[31] ? (32'd0 - w_num) : w_num;
        r_c_mb   <= w_den[31] ? (32'd0 - w_den) : w_den;
        r_c_neg  <= w_num[31] ^ w_den[31];
        r_c_zero <= (w_den == 32'd0);
        r_c_x1   <= r_b_x1;
        r_c_up   <= r_b_up;
    end

    // Temperature divider
    logic          w_d1_v;
    logic [31:0]   w_d1_q;
    logic [SW-1:0] w_d1_side;
    bsc_div u_div_t (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_c_v),
        .i_dvd  (r_c_ma),
        .i_dvs  (r_c_mb),
        .i_side ({r_c_zero, r_c_neg, r_c_up, r_c_x1}),
        .o_vld  (w_d1_v),
        .o_quo  (w_d1_q),
        .o_side (w_d1_side)
    );

    // Stage D: b5 = x1 + x2
    logic        r_d_v, r_d_zero;
    logic [31:0] r_d_b5;
    logic [15:0] r_d_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else          r_d_v <= w_d1_v;
        r_d_b5   <= w_d1_side[31:0] + (w_d1_side[48] ? (32'd0 - w_d1_q) : w_d1_q);
        r_d_up   <= w_d1_side[47:32];
        r_d_zero <= w_d1_side[49];
    end

    // Stage E: temperature result and b6
    logic [31:0] w_b5p8;
    logic        r_e_v, r_e_zero;
    logic [31:0] r_e_b6;
    logic [15:0] r_e_t, r_e_up;
    assign w_b5p8 = r_d_b5 + 32'd8;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_e_v <= 1'b0;
        else          r_e_v <= r_d_v;
        r_e_t    <= w_b5p8[19:4];
        r_e_b6   <= r_d_b5 - bsc_pkg::C_4000;
        r_e_up   <= r_d_up;
        r_e_zero <= r_d_zero;
    end

    // Stage F: b8, b6*ac2, b6*ac3
    logic [31:0] w_b6sq, w_b6a3;
    logic        r_f_v, r_f_zero;
    logic [31:0] r_f_b8, r_f_b6a2, r_f_x1;
    logic [15:0] r_f_t, r_f_up;
    assign w_b6sq = r_e_b6 * r_e_b6;
    assign w_b6a3 = r_e_b6 * w_ac3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f_v <= 1'b0;
        else          r_f_v <= r_e_v;
        r_f_b8   <= $unsigned($signed(w_b6sq) >>> 12);
        r_f_b6a2 <= r_e_b6 * w_ac2;
        r_f_x1   <= $unsigned($signed(w_b6a3) >>> 13);
        r_f_t    <= r_e_t;
        r_f_up   <= r_e_up;
        r_f_zero <= r_e_zero;
    end

    // Stage G: b8*b2, b8*b1
    logic [31:0] w_b8b1;
    logic        r_g_v, r_g_zero;
    logic [31:0] r_g_b8b2, r_g_x2, r_g_b6a2, r_g_x1;
    logic [15:0] r_g_t, r_g_up;
    assign w_b8b1 = r_f_b8 * w_b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_g_v <= 1'b0;
        else          r_g_v <= r_f_v;
        r_g_b8b2 <= r_f_b8 * w_b2;
        r_g_x2   <= $unsigned($signed(w_b8b1) >>> 16);
        r_g_b6a2 <= r_f_b6a2;
        r_g_x1   <= r_f_x1;
        r_g_t    <= r_f_t;
        r_g_up   <= r_f_up;
        r_g_zero <= r_f_zero;
    end

    // Stage H: both x3 terms
    logic [31:0] w_x3a, w_x3b;
    logic        r_h_v, r_h_zero;
    logic [31:0] r_h_x3a, r_h_x3b;
    logic [15:0] r_h_t, r_h_up;
    assign w_x3a = r_g_b8b2 + r_g_b6a2;
    assign w_x3b = r_g_x1 + r_g_x2 + 32'd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_h_v <= 1'b0;
        else          r_h_v <= r_g_v;
        r_h_x3a  <= $unsigned($signed(w_x3a) >>> 11);
        r_h_x3b  <= $unsigned($signed(w_x3b) >>> 2);
        r_h_t    <= r_g_t;
        r_h_up   <= r_g_up;
        r_h_zero <= r_g_zero;
    end

    // Stage I: b3 and the b4 multiplicand
    logic [31:0] w_b3s;
    logic        r_i_v, r_i_zero;
    logic [31:0] r_i_b3, r_i_m;
    logic [15:0] r_i_t, r_i_up;
    assign w_b3s = r_h_x3a + (w_ac1 << 2) + 32'd2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_i_v <= 1'b0;
        else          r_i_v <= r_h_v;
        r_i_b3   <= $unsigned($signed(w_b3s) >>> 2);
        r_i_m    <= r_h_x3b + bsc_pkg::C_32768;
        r_i_t    <= r_h_t;
        r_i_up   <= r_h_up;
        r_i_zero <= r_h_zero;
    end

    // Stage J: b4 and b7
    logic [31:0] w_b4p;
    logic        r_j_v, r_j_zero;
    logic [31:0] r_j_b4, r_j_b7;
    logic [15:0] r_j_t;
    assign w_b4p = w_ac4 * r_i_m;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_j_v <= 1'b0;
        else          r_j_v <= r_i_v;
        r_j_b4   <= w_b4p >> 15;
        r_j_b7   <= ({16'd0, r_i_up} - r_i_b3) * bsc_pkg::C_50000;
        r_j_t    <= r_i_t;
        r_j_zero <= r_i_zero;
    end

    // Pressure divider: p = (b7 / b4) << 1
    logic          w_d2_v;
    logic [31:0]   w_d2_q;
    logic [SW-1:0] w_d2_side;
    logic          w_err_j;
    assign w_err_j = r_j_zero || (r_j_b4 == 32'd0);
    bsc_div u_div_p (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_j_v),
        .i_dvd  (r_j_b7),
        .i_dvs  (r_j_b4),
        .i_side ({(SW-17)'(0), w_err_j, r_j_t}),
        .o_vld  (w_d2_v),
        .o_quo  (w_d2_q),
        .o_side (w_d2_side)
    );

    // Stage L: p squared term and linear term
    logic [31:0] w_p, w_pa, w_plin;
    logic        r_l_v, r_l_err;
    logic [31:0] r_l_p, r_l_sq, r_l_x2;
    logic [15:0] r_l_t;
    assign w_p    = w_d2_q << 1;
    assign w_pa   = $unsigned($signed(w_p) >>> 8);
    assign w_plin = bsc_pkg::C_M7357 * w_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_l_v <= 1'b0;
        else          r_l_v <= w_d2_v;
        r_l_p   <= w_p;
        r_l_sq  <= w_pa * w_pa;
        r_l_x2  <= $unsigned($signed(w_plin) >>> 16);
        r_l_t   <= w_d2_side[15:0];
        r_l_err <= w_d2_side[16];
    end

    // Stage M: x1 = sq * 3038 >> 16
    logic [31:0] w_sq3;
    logic        r_m_v, r_m_err;
    logic [31:0] r_m_p, r_m_x1, r_m_x2;
    logic [15:0] r_m_t;
    assign w_sq3 = r_l_sq * bsc_pkg::C_3038;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else          r_m_v <= r_l_v;
        r_m_x1  <= $unsigned($signed(w_sq3) >>> 16);
        r_m_p   <= r_l_p;
        r_m_x2  <= r_l_x2;
        r_m_t   <= r_l_t;
        r_m_err <= r_l_err;
    end

    // Stage N: corrected pressure in Pa
    logic [31:0] w_corr;
    logic        r_n_v, r_n_err;
    logic [31:0] r_n_sum;
    logic [15:0] r_n_t;
    assign w_corr = r_m_x1 + r_m_x2 + bsc_pkg::C_3791;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_n_v <= 1'b0;
        else          r_n_v <= r_m_v;
        r_n_sum <= r_m_p + $unsigned($signed(w_corr) >>> 4);
        r_n_t   <= r_m_t;
        r_n_err <= r_m_err;
    end

    // Stage O: times 3, split sign for the divide by 40
    logic [31:0] w_v3;
    logic        r_o_v, r_o_err, r_o_neg;
    logic [31:0] r_o_mag;
    logic [15:0] r_o_t;
    assign w_v3 = (r_n_sum << 1) + r_n_sum;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else          r_o_v <= r_n_v;
        r_o_neg <= w_v3[31];
        r_o_mag <= w_v3[31] ? (32'd0 - w_v3) : w_v3;
        r_o_t   <= r_n_t;
        r_o_err <= r_n_err;
    end

    // Stage P: mag / 40 as (mag >> 3) / 5, reciprocal multiply exact below 2^32
    logic [60:0] w_q5;
    logic        r_p_v, r_p_err, r_p_neg;
    logic [31:0] r_p_q, w_pr;
    logic [15:0] r_p_t;
    assign w_q5 = {32'd0, r_o_mag[31:3]} * {29'd0, 32'hCCCC_CCCD};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_v <= 1'b0;
        else          r_p_v <= r_o_v;
        r_p_q   <= {5'd0, w_q5[60:34]};
        r_p_neg <= r_o_neg;
        r_p_t   <= r_o_t;
        r_p_err <= r_o_err;
    end
    assign w_pr = r_p_neg ? (32'd0 - r_p_q) : r_p_q;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_p_v;
        o_div_error         <= r_p_err;
        o_temp_tenths_c     <= r_p_err ? 16'sd0 : $signed(r_p_t);
        o_press_tenths_mmhg <= r_p_err ? 16'sd0 : $signed(w_pr[15:0]);
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_error |-> o_temp_tenths_c == 16'sd0 && o_press_tenths_mmhg == 16'sd0)
        else $error("error result with nonzero fields");
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && i_cfg_index == bsc_pkg::REG_MC_MD
        |=> r_cal[bsc_pkg::REG_MC_MD] == $past(i_cfg_data))
        else $error("calibration write lost");
    a_tzero_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && r_d_zero |=> r_e_v && r_e_zero)
        else $error("temperature divisor error flag dropped");
`endif

endmodule

// File: tb/barometric_sensor_compensation_tb.sv
// Testbench for the barometric sensor compensation block: directed and random checks.
`timescale 1ns / 100ps

module barometric_sensor_compensation_tb;

    localparam int LATENCY   = 81;
    localparam int WDOG_MAX  = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_raw_temp;
    logic [15:0] i_raw_press;
    logic        o_valid;
    logic signed [15:0] o_temp_tenths_c;
    logic signed [15:0] o_press_tenths_mmhg;
    logic        o_div_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [bsc_pkg::IDX_W-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    typedef struct packed {
        logic [15:0] temp;
        logic [15:0] press;
        logic        err;
    } t_comp_result;

    // Local copy of the calibration words
    logic [31:0] cal_words [bsc_pkg::NUM_REGS];
    t_comp_result pending_results [$];
    int n_errors;
    int n_items;
    int n_results;
    int n_div_err;
    int idle_cycles;

    barometric_sensor_compensation u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_raw_temp          (i_raw_temp),
        .i_raw_press         (i_raw_press),
        .o_valid             (o_valid),
        .o_temp_tenths_c     (o_temp_tenths_c),
        .o_press_tenths_mmhg (o_press_tenths_mmhg),
        .o_div_error         (o_div_error),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Arithmetic right shift on a 32-bit word
    function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    // Signed division, truncating toward zero
    function automatic logic [31:0] sdiv32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensated temperature and pressure for one raw pair
    function automatic t_comp_result compensate(input logic [15:0] ut16,
                                                input logic [15:0] up16);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, b8, p, den, t, pr;
        t_comp_result r;
        ac1 = sext16(cal_words[bsc_pkg::REG_AC1_AC2][31:16]);
        ac2 = sext16(cal_words[bsc_pkg::REG_AC1_AC2][15:0]);
        ac3 = sext16(cal_words[bsc_pkg::REG_AC3_AC4][31:16]);
        ac4 = {16'd0, cal_words[bsc_pkg::REG_AC3_AC4][15:0]};
        ac5 = {16'd0, cal_words[bsc_pkg::REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal_words[bsc_pkg::REG_AC5_AC6][15:0]};
        b1  = sext16(cal_words[bsc_pkg::REG_B1_B2][31:16]);
        b2  = sext16(cal_words[bsc_pkg::REG_B1_B2][15:0]);
        mc  = sext16(cal_words[bsc_pkg::REG_MC_MD][31:16]);
        md  = sext16(cal_words[bsc_pkg::REG_MC_MD][15:0]);
        ut  = {16'd0, ut16};
        up  = {16'd0, up16};
        r   = '{temp: 16'd0, press: 16'd0, err: 1'b1};

        x1  = sra32((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 32'd0) return r;
        x2 = sdiv32(mc << 11, den);
        b5 = x1 + x2;
        t  = sra32(b5 + 32'd8, 4);

        b6 = b5 - bsc_pkg::C_4000;
        b8 = sra32(b6 * b6, 12);
        x3 = sra32(b8 * b2 + b6 * ac2, 11);
        b3 = sra32(x3 + 32'd4 * ac1 + 32'd2, 2);
        x1 = sra32(b6 * ac3, 13);
        x2 = sra32(b8 * b1, 16);
        x3 = sra32(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + bsc_pkg::C_32768)) >> 15;
        if (b4 == 32'd0) return r;
        b7 = (up - b3) * bsc_pkg::C_50000;
        p  = (b7 / b4) << 1;

        x1 = sra32(p, 8) * sra32(p, 8);
        x1 = sra32(x1 * bsc_pkg::C_3038, 16);
        x2 = sra32(bsc_pkg::C_M7357 * p, 16);
        pr = sdiv32((p + sra32(x1 + x2 + bsc_pkg::C_3791, 4)) * 32'd3, bsc_pkg::C_40);
        r  = '{temp: t[15:0], press: pr[15:0], err: 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_comp_result want;
            n_results++;
            if (pending_results.size() == 0) begin
                $display("MISMATCH unexpected result at %0t", $realtime);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_div_error) n_div_err++;
                if (o_temp_tenths_c !== want.temp)
                    report_mismatch("temp", o_temp_tenths_c, want.temp);
                if (o_press_tenths_mmhg !== want.press)
                    report_mismatch("press", o_press_tenths_mmhg, want.press);
                if (o_div_error !== want.err)
                    report_mismatch("div_error", {15'd0, o_div_error}, {15'd0, want.err});
            end
        end
    end

    // Watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("watchdog expired");
            $display("barometric_sensor_compensation_tb: FAIL");
            $finish;
        end
    end

    // Random gap length, mostly short and now and then long
    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        return n;
    endfunction

    // Send one raw pair; start stays high when the next call follows at once
    task automatic send_sample(input logic [15:0] ut, input logic [15:0] up,
                               input bit use_gaps);
        int n;
        n = use_gaps ? gap_len() : 0;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_raw_temp  <= ut;
        i_raw_press <= up;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(compensate(ut, up));
        n_items++;
    endtask

    task automatic end_burst();
        start <= 1'b0;
    endtask

    // Let the pipeline drain before touching calibration
    task automatic drain();
        int guard;
        end_burst();
        guard = 0;
        while (pending_results.size() != 0 && guard < 4 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cal(input bsc_pkg::t_reg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cal_words[idx] = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Typical factory calibration from a real part
    task automatic load_typical_cal();
        write_cal(bsc_pkg::REG_AC1_AC2, {16'sd408, -16'sd72});
        write_cal(bsc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741});
        write_cal(bsc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
        write_cal(bsc_pkg::REG_B1_B2,   {16'sd6190, 16'sd4});
        write_cal(bsc_pkg::REG_MC_MD,   {-16'sd8711, 16'sd2868});
    endtask

    task automatic load_random_cal();
        for (int i = 0; i < bsc_pkg::NUM_REGS; i++)
            write_cal(bsc_pkg::t_reg_idx'(i), $urandom());
    endtask

    // Directed values: field extremes and typical readings
    task automatic test_directed_typical();
        load_typical_cal();
        send_sample(16'd27898, 16'd23843, 0);
        send_sample(16'h0000, 16'h0000, 0);
        send_sample(16'hFFFF, 16'hFFFF, 0);
        send_sample(16'h0000, 16'hFFFF, 1);
        send_sample(16'hFFFF, 16'h0000, 0);
        send_sample(16'h5555, 16'hAAAA, 0);
        send_sample(16'hAAAA, 16'h5555, 1);
        send_sample(16'd23153, 16'd40000, 0);
        drain();
    endtask

    // Zero temperature divisor: md cancels x1, here with ut == ac6 and md == 0
    task automatic test_zero_temp_divisor();
        write_cal(bsc_pkg::REG_MC_MD, {-16'sd8711, 16'sd0});
        send_sample(16'd23153, 16'd30000, 0);
        send_sample(16'd23153, 16'd0, 0);
        send_sample(16'd27898, 16'd30000, 0);
        drain();
        write_cal(bsc_pkg::REG_MC_MD, {-16'sd8711, 16'sd2868});
    endtask

    // Zero pressure divisor: ac4 == 0 forces b4 to zero
    task automatic test_zero_press_divisor();
        write_cal(bsc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd0});
        send_sample(16'd27898, 16'd23843, 0);
        send_sample(16'hFFFF, 16'hFFFF, 1);
        drain();
    endtask

    // Calibration extremes: all ones, sign boundaries
    task automatic test_cal_extremes();
        for (int i = 0; i < bsc_pkg::NUM_REGS; i++)
            write_cal(bsc_pkg::t_reg_idx'(i), 32'hFFFF_FFFF);
        send_sample(16'h0000, 16'h0000, 0);
        send_sample(16'hFFFF, 16'hFFFF, 0);
        send_sample(16'h8000, 16'h7FFF, 0);
        drain();
        for (int i = 0; i < bsc_pkg::NUM_REGS; i++)
            write_cal(bsc_pkg::t_reg_idx'(i), 32'h8000_7FFF);
        send_sample(16'h1234, 16'hFEDC, 0);
        send_sample(16'hFFFF, 16'h0001, 0);
        drain();
        for (int i = 0; i < bsc_pkg::NUM_REGS; i++)
            write_cal(bsc_pkg::t_reg_idx'(i), 32'h7FFF_8000);
        send_sample(16'h8000, 16'h8000, 0);
        drain();
    endtask

    // Random pairs over one calibration set, with gaps on the sender after the first third
    task automatic test_random(input int per_phase, input bit typical);
        if (typical) load_typical_cal(); else load_random_cal();
        for (int i = 0; i < per_phase; i++) begin
            logic [15:0] ut, up;
            ut = typical ? 16'($urandom_range(20000, 35000)) : 16'($urandom());
            up = typical ? 16'($urandom_range(15000, 45000)) : 16'($urandom());
            if ($urandom_range(0, 9) == 0) ut = 16'($urandom());
            send_sample(ut, up, i >= per_phase / 3);
        end
        drain();
    endtask

    initial begin
        start       = 1'b0;
        i_raw_temp  = '0;
        i_raw_press = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        idle_cycles = 0;
        n_errors    = 0;
        n_items     = 0;
        n_results   = 0;
        n_div_err   = 0;
        for (int i = 0; i < bsc_pkg::NUM_REGS; i++) cal_words[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: all zero, so every item flags a divide error
        send_sample(16'd27898, 16'd23843, 0);
        drain();

        test_directed_typical();
        test_zero_temp_divisor();
        test_zero_press_divisor();
        test_cal_extremes();
        for (int ph = 0; ph < 6; ph++)
            test_random(100, ph % 2 == 0);

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            n_errors++;
        end
        $display("Sent %0d raw pairs over typical, random and extreme calibrations;",
                 n_items);
        $display("checked %0d results, %0d of them divide errors.", n_results, n_div_err);
        if (n_errors == 0) begin
            $display("barometric_sensor_compensation_tb: PASS");
        end else begin
            $display("barometric_sensor_compensation_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/bsc_pkg.sv
sv/bsc_div.sv
sv/barometric_sensor_compensation.sv
tb/barometric_sensor_compensation_tb.sv
